/* rtl/core/stl_pkg.sv */
// ----------------------------------------------------------------------------
// stl_pkg
// Shared types and constants of the source token lexer: lexer modes, token
// kinds, character codes, keyword patterns and the front-to-back queue entry.
// ----------------------------------------------------------------------------
package stl_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_NAME = 2'd1,
        MODE_NUM  = 2'd2,
        MODE_SKIP = 2'd3
    } t_mode;

    typedef enum logic [4:0] {
        KIND_LET       = 5'd0,
        KIND_FUNC      = 5'd1,
        KIND_PRINT     = 5'd2,
        KIND_IDENT     = 5'd3,
        KIND_NUMBER    = 5'd4,
        KIND_PLUS      = 5'd5,
        KIND_MINUS     = 5'd6,
        KIND_MULTIPLY  = 5'd7,
        KIND_DIVIDE    = 5'd8,
        KIND_ASSIGN    = 5'd9,
        KIND_SEMICOLON = 5'd10,
        KIND_LPAREN    = 5'd11,
        KIND_RPAREN    = 5'd12,
        KIND_LBRACE    = 5'd13,
        KIND_RBRACE    = 5'd14,
        KIND_COMMA     = 5'd15,
        KIND_END       = 5'd16,
        KIND_ERROR     = 5'd17
    } t_kind;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;

    // keywords packed first byte lowest
    localparam logic [63:0] KW_LET   = 64'h0000_0000_0074_656C;
    localparam logic [63:0] KW_FUNC  = 64'h0000_0000_636E_7566;
    localparam logic [63:0] KW_PRINT = 64'h0000_0074_6E69_7270;
    localparam logic [3:0]  LEN_LET   = 4'd3;
    localparam logic [3:0]  LEN_FUNC  = 4'd4;
    localparam logic [3:0]  LEN_PRINT = 4'd5;

    localparam logic [30:0] NUM_LIMIT = 31'h7FFF_FFFF;

    localparam int QDEPTH = 4;

    typedef struct packed {
        t_kind       kind;
        logic [63:0] text;
        logic [3:0]  len;
        logic        trunc;
        logic [30:0] num;
        logic        sat;
        logic [7:0]  bad;
    } t_tok;

    // one accepted byte: a held end token, up to two tokens and an end token
    typedef struct packed {
        logic owed;
        logic a_vld;
        logic a_last;
        t_tok a;
        logic b_vld;
        logic b_last;
        t_tok b;
        logic end_vld;
    } t_entry;

    typedef struct packed {
        logic   push;
        t_entry entry;
    } t_push;

endpackage

/* rtl/core/stl_src_if.sv */
// ----------------------------------------------------------------------------
// stl_src_if
// Source byte channel: valid/ready handshake with one byte and its final flag.
// ----------------------------------------------------------------------------
interface stl_src_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       final_byte;

    modport source  (output valid, output char_byte, output final_byte, input ready);
    modport sink    (input valid, input char_byte, input final_byte, output ready);
    modport monitor (input valid, input char_byte, input final_byte, input ready);
endinterface

/* rtl/core/stl_tok_if.sv */
// ----------------------------------------------------------------------------
// stl_tok_if
// Token channel: valid/ready handshake with the fields of one token.
// ----------------------------------------------------------------------------
interface stl_tok_if;
    logic        valid;
    logic        ready;
    logic [4:0]  token_kind;
    logic [63:0] ident_text;
    logic [3:0]  ident_length;
    logic        ident_truncated;
    logic [30:0] number_value;
    logic        number_saturated;
    logic [7:0]  bad_byte;
    logic        run_last;

    modport source (
        output valid, output token_kind, output ident_text, output ident_length,
        output ident_truncated, output number_value, output number_saturated,
        output bad_byte, output run_last, input ready
    );
    modport sink (
        input valid, input token_kind, input ident_text, input ident_length,
        input ident_truncated, input number_value, input number_saturated,
        input bad_byte, input run_last, output ready
    );
    modport monitor (
        input valid, input token_kind, input ident_text, input ident_length,
        input ident_truncated, input number_value, input number_saturated,
        input bad_byte, input run_last, input ready
    );
endinterface

/* rtl/core/source_token_lexer_unit.sv */
// ----------------------------------------------------------------------------
// source_token_lexer_unit
// Byte-stream tokenizer: identifiers with keyword check, saturating decimal
// numbers, punctuation, end and error tokens.
// ----------------------------------------------------------------------------
//  channel | dir | handshake      | payload
//  i_src   | in  | valid / ready  | char_byte, final_byte
//  o_tok   | out | valid / ready  | token_kind, ident_*, number_*, bad_byte,
//          |     |                | run_last
//
//  one byte is taken per cycle while the 4-entry queue has room
//  each accepted byte that yields tokens fills one queue entry; the back end
//  drains an entry at one token per cycle while the output is not stalled
//  first token of a byte goes through a queue entry, then the output register
//  synchronous active-low reset clears lexer mode, queue and output valid
//  a stalled output keeps its token; bytes keep flowing until the queue fills
// ----------------------------------------------------------------------------
module source_token_lexer_unit #(
    parameter int MAX_ID_BYTES = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    stl_src_if.sink   i_src,
    stl_tok_if.source o_tok
);
    import stl_pkg::*;

    t_push  push;
    logic   q_full;
    logic   pop;
    logic   head_vld;
    t_entry head;

    stl_front #(
        .MAX_ID_BYTES (MAX_ID_BYTES)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_src    (i_src),
        .i_q_full (q_full),
        .o_push   (push)
    );

    stl_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (q_full),
        .i_pop      (pop),
        .o_head_vld (head_vld),
        .o_head     (head)
    );

    stl_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head_vld (head_vld),
        .i_head     (head),
        .o_pop      (pop),
        .o_tok      (o_tok)
    );

endmodule

/* rtl/core/stl_front.sv */
// ----------------------------------------------------------------------------
// stl_front
// Byte classifier and lexer state. Takes one byte per cycle while the queue is not
// full, updates the pending identifier or number, and pushes the tokens that byte causes.
// ----------------------------------------------------------------------------
module stl_front #(
    parameter int MAX_ID_BYTES = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    stl_src_if.sink       i_src,
    input  logic          i_q_full,
    output stl_pkg::t_push o_push
);
    import stl_pkg::*;

    localparam int         BUF_W   = 8 * MAX_ID_BYTES;
    localparam int         IDX_W   = $clog2(MAX_ID_BYTES);
    localparam logic [3:0] MAX_CNT = 4'(MAX_ID_BYTES);

    t_mode            r_mode, n_mode;
    logic [BUF_W-1:0] r_buf, n_buf;
    logic [3:0]       r_cnt, n_cnt;
    logic             r_ovf, n_ovf;
    logic [30:0]      r_acc, n_acc;
    logic             r_dovf, n_dovf;
    logic             r_owed, n_owed;

    logic [7:0]       c;
    logic             fin, accept;
    logic             is_alpha, is_digit, is_space, is_punct, is_nul, is_err;
    logic             extend;
    t_kind            p_kind;
    logic [3:0]       d;

    logic [BUF_W-1:0] u_buf;
    logic [3:0]       u_cnt;
    logic             u_ovf;
    logic [34:0]      u_sum;
    logic             u_sat;
    logic [30:0]      u_acc;
    logic             u_dovf;

    logic             a_vld, b_vld, end_vld, three;
    t_tok             a_tok, b_tok;

    function automatic t_tok tok_of(input logic is_name, input logic [63:0] nbuf,
                                    input logic [3:0] ncnt, input logic novf,
                                    input logic [30:0] acc, input logic dovf);
        t_tok t;
        t = '0;
        if (is_name) begin
            if (!novf && ncnt == LEN_LET && nbuf == KW_LET) begin
                t.kind = KIND_LET;
            end else if (!novf && ncnt == LEN_FUNC && nbuf == KW_FUNC) begin
                t.kind = KIND_FUNC;
            end else if (!novf && ncnt == LEN_PRINT && nbuf == KW_PRINT) begin
                t.kind = KIND_PRINT;
            end else begin
                t.kind  = KIND_IDENT;
                t.text  = nbuf;
                t.len   = ncnt;
                t.trunc = novf;
            end
        end else begin
            t.kind = KIND_NUMBER;
            t.num  = acc;
            t.sat  = dovf;
        end
        return t;
    endfunction

    assign c      = i_src.char_byte;
    assign fin    = i_src.final_byte;
    assign accept = i_src.valid && i_src.ready;
    assign i_src.ready = !i_q_full;

    assign is_nul   = (c == CH_NUL);
    assign is_alpha = (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z)
                      || (c == CH_UNDER);
    assign is_digit = (c >= CH_ZERO && c <= CH_NINE);
    assign is_space = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    assign d        = c[3:0];

    always_comb begin
        is_punct = 1'b1;
        unique case (c)
            CH_PLUS:   p_kind = KIND_PLUS;
            CH_MINUS:  p_kind = KIND_MINUS;
            CH_STAR:   p_kind = KIND_MULTIPLY;
            CH_SLASH:  p_kind = KIND_DIVIDE;
            CH_EQUAL:  p_kind = KIND_ASSIGN;
            CH_SEMI:   p_kind = KIND_SEMICOLON;
            CH_LPAREN: p_kind = KIND_LPAREN;
            CH_RPAREN: p_kind = KIND_RPAREN;
            CH_LBRACE: p_kind = KIND_LBRACE;
            CH_RBRACE: p_kind = KIND_RBRACE;
            CH_COMMA:  p_kind = KIND_COMMA;
            default: begin
                p_kind   = KIND_ERROR;
                is_punct = 1'b0;
            end
        endcase
    end

    assign extend = (r_mode == MODE_NAME && (is_alpha || is_digit))
                    || (r_mode == MODE_NUM && is_digit);
    assign is_err = (r_mode != MODE_SKIP) && !is_nul && !extend && !is_alpha && !is_digit
                    && !is_space && !is_punct;

    // pending name or number with this byte appended
    always_comb begin
        u_buf = r_buf;
        u_cnt = r_cnt;
        u_ovf = r_ovf;
        if (r_cnt < MAX_CNT) begin
            u_buf[8*r_cnt[IDX_W-1:0] +: 8] = c;
            u_cnt = r_cnt + 4'd1;
        end else begin
            u_ovf = 1'b1;
        end
        u_sum  = 35'({r_acc, 3'b000}) + 35'({r_acc, 1'b0}) + 35'(d);
        u_sat  = u_sum > 35'(NUM_LIMIT);
        u_acc  = u_sat ? NUM_LIMIT : u_sum[30:0];
        u_dovf = r_dovf || u_sat;
    end

    // next mode
    always_comb begin
        n_mode = r_mode;
        if (accept) begin
            unique case (r_mode)
                MODE_SKIP: begin
                    n_mode = (is_nul || fin) ? MODE_IDLE : MODE_SKIP;
                end
                MODE_IDLE, MODE_NAME, MODE_NUM: begin
                    if (is_nul || fin) begin
                        n_mode = MODE_IDLE;
                    end else if (extend) begin
                        n_mode = r_mode;
                    end else if (is_alpha) begin
                        n_mode = MODE_NAME;
                    end else if (is_digit) begin
                        n_mode = MODE_NUM;
                    end else if (is_err) begin
                        n_mode = MODE_SKIP;
                    end else begin
                        n_mode = MODE_IDLE;
                    end
                end
                default: n_mode = MODE_IDLE;
            endcase
        end
    end

    // tokens and pending data
    always_comb begin
        a_vld   = 1'b0;
        b_vld   = 1'b0;
        end_vld = 1'b0;
        b_tok   = '0;
        if (extend) begin
            a_tok = tok_of(r_mode == MODE_NAME, 64'(u_buf), u_cnt, u_ovf, u_acc, u_dovf);
        end else begin
            a_tok = tok_of(r_mode == MODE_NAME, 64'(r_buf), r_cnt, r_ovf, r_acc, r_dovf);
        end
        n_buf  = '0;
        n_cnt  = '0;
        n_ovf  = 1'b0;
        n_acc  = '0;
        n_dovf = 1'b0;

        if (r_mode != MODE_SKIP) begin
            if (is_nul) begin
                a_vld   = (r_mode != MODE_IDLE);
                end_vld = 1'b1;
            end else if (extend) begin
                a_vld   = fin;
                end_vld = fin;
                if (!fin) begin
                    n_buf  = u_buf;
                    n_cnt  = u_cnt;
                    n_ovf  = u_ovf;
                    n_acc  = u_acc;
                    n_dovf = u_dovf;
                end
            end else begin
                a_vld   = (r_mode != MODE_IDLE);
                end_vld = fin && !is_err;
                if (is_alpha) begin
                    b_vld      = fin;
                    b_tok.kind = KIND_IDENT;
                    b_tok.text = 64'(c);
                    b_tok.len  = 4'd1;
                    if (!fin) begin
                        n_buf[7:0] = c;
                        n_cnt      = 4'd1;
                    end
                end else if (is_digit) begin
                    b_vld      = fin;
                    b_tok.kind = KIND_NUMBER;
                    b_tok.num  = 31'(d);
                    if (!fin) begin
                        n_acc = 31'(d);
                    end
                end else if (is_punct) begin
                    b_vld      = 1'b1;
                    b_tok.kind = p_kind;
                end else if (is_err) begin
                    b_vld      = 1'b1;
                    b_tok.kind = KIND_ERROR;
                    b_tok.bad  = c;
                end
            end
        end
    end

    // a third token, counting a held end token, is the end token; it is held
    // for the next byte
    assign three  = end_vld && b_vld && (a_vld || r_owed);
    assign n_owed = three;

    always_comb begin
        o_push.push           = accept && (r_owed || a_vld || b_vld || end_vld);
        o_push.entry.owed     = r_owed;
        o_push.entry.a_vld    = a_vld;
        o_push.entry.a_last   = a_vld && !b_vld && !end_vld;
        o_push.entry.a        = a_tok;
        o_push.entry.b_vld    = b_vld;
        o_push.entry.b_last   = b_vld && !end_vld;
        o_push.entry.b        = b_tok;
        o_push.entry.end_vld  = end_vld && !three;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_buf  <= '0;
            r_cnt  <= '0;
            r_ovf  <= 1'b0;
            r_acc  <= '0;
            r_dovf <= 1'b0;
            r_owed <= 1'b0;
        end else begin
            r_mode <= n_mode;
            if (accept) begin
                r_buf  <= n_buf;
                r_cnt  <= n_cnt;
                r_ovf  <= n_ovf;
                r_acc  <= n_acc;
                r_dovf <= n_dovf;
                r_owed <= n_owed;
            end
        end
    end

endmodule

/* rtl/core/stl_queue.sv */
// ----------------------------------------------------------------------------
// stl_queue
// Short entry queue between the byte front end and the token back end.
// ----------------------------------------------------------------------------
module stl_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  stl_pkg::t_push  i_push,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_head_vld,
    output stl_pkg::t_entry o_head
);
    import stl_pkg::*;

    localparam int PW = $clog2(QDEPTH);

    t_entry        r_mem [QDEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [PW:0]   r_cnt;
    logic          do_pop;

    assign o_full     = (r_cnt == (PW+1)'(QDEPTH));
    assign o_head_vld = (r_cnt != '0);
    assign o_head     = r_mem[r_rd];
    assign do_pop     = i_pop && o_head_vld;

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wr] <= i_push.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push.push) begin
                r_wr <= r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + PW'(1);
            end
            r_cnt <= r_cnt + (PW+1)'(i_push.push) - (PW+1)'(do_pop);
        end
    end

endmodule

/* rtl/core/stl_back.sv */
// ----------------------------------------------------------------------------
// stl_back
// Token sequencer: walks the tokens of the head queue entry in order and
// loads them one per cycle, while the output is not stalled, into the output register.
// ----------------------------------------------------------------------------
module stl_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_head_vld,
    input  stl_pkg::t_entry i_head,
    output logic            o_pop,
    stl_tok_if.source       o_tok
);
    import stl_pkg::*;

    // bit 0 held end, bit 1 token a, bit 2 token b, bit 3 end
    logic [3:0] r_done;
    logic [3:0] pend, sel, rest;
    logic       load, last_item;
    logic       r_out_valid;
    t_tok       r_out_tok;
    logic       r_out_last;
    t_tok       sel_tok;
    logic       sel_last;
    t_tok       end_tok;

    always_comb begin
        end_tok      = '0;
        end_tok.kind = KIND_END;
    end

    assign pend      = {i_head.end_vld, i_head.b_vld, i_head.a_vld, i_head.owed} & ~r_done;
    assign sel       = pend & (~pend + 4'd1);
    assign rest      = pend & ~sel;
    assign last_item = (rest == '0);
    assign load      = i_head_vld && (!r_out_valid || o_tok.ready);
    assign o_pop     = load && last_item;

    always_comb begin
        if (sel[1]) begin
            sel_tok  = i_head.a;
            sel_last = i_head.a_last;
        end else if (sel[2]) begin
            sel_tok  = i_head.b;
            sel_last = i_head.b_last;
        end else begin
            sel_tok  = end_tok;
            sel_last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_tok  <= sel_tok;
            r_out_last <= sel_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_done      <= last_item ? 4'b0000 : (r_done | sel);
                r_out_valid <= 1'b1;
            end else if (o_tok.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_tok.valid            = r_out_valid;
    assign o_tok.token_kind       = r_out_tok.kind;
    assign o_tok.ident_text       = r_out_tok.text;
    assign o_tok.ident_length     = r_out_tok.len;
    assign o_tok.ident_truncated  = r_out_tok.trunc;
    assign o_tok.number_value     = r_out_tok.num;
    assign o_tok.number_saturated = r_out_tok.sat;
    assign o_tok.bad_byte         = r_out_tok.bad;
    assign o_tok.run_last         = r_out_last;

endmodule

/* rtl/core/stl_checker.sv */
// ----------------------------------------------------------------------------
// stl_checker
// Port-level checks on the token output of the lexer, bound to the top level.
// ----------------------------------------------------------------------------
module stl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [4:0]  i_token_kind,
    input logic [63:0] i_ident_text,
    input logic [3:0]  i_ident_length,
    input logic [7:0]  i_bad_byte,
    input logic        i_run_last
);
    import stl_pkg::*;

    // a stalled request stays up
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("token valid dropped while stalled");

    // only identifiers carry name bytes
    a_ident_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_token_kind != KIND_IDENT
        |-> i_ident_length == 4'd0 && i_ident_text == 64'd0)
        else $error("name fields set on a non-identifier token");

    // end token always closes the tokens of its byte
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_token_kind == KIND_END |-> i_run_last)
        else $error("end token without run_last");

    // error token carries a nonzero byte and closes its byte's tokens
    a_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_token_kind == KIND_ERROR
        |-> i_bad_byte != 8'd0 && i_run_last)
        else $error("malformed error token");

    // identifier length bounded by the buffer
    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_token_kind == KIND_IDENT
        |-> i_ident_length != 4'd0 && i_ident_length <= 4'd8)
        else $error("identifier length out of range");

endmodule

bind source_token_lexer_unit stl_checker u_stl_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (o_tok.valid),
    .i_ready        (o_tok.ready),
    .i_token_kind   (o_tok.token_kind),
    .i_ident_text   (o_tok.ident_text),
    .i_ident_length (o_tok.ident_length),
    .i_bad_byte     (o_tok.bad_byte),
    .i_run_last     (o_tok.run_last)
);
